[rtl/dtv_pkg.sv]
// ----------------------------------------------------------------------------
// dtv_pkg: shared definitions of the dtmf tone validator
// Widths, register indexes, lane status struct and the keypad table.
// ----------------------------------------------------------------------------
package dtv_pkg;

  // default energy and ratio format
  localparam int unsigned ENERGY_BITS_DEF     = 24;
  localparam int unsigned RATIO_FRAC_BITS_DEF = 12;

  // fixed widths
  localparam int unsigned RATIO_BITS     = 16;
  localparam int unsigned CFG_DATA_BITS  = 32;
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned GROUP_BINS     = 4;
  localparam int unsigned BIN_IDX_BITS   = 2;
  localparam int unsigned KEY_BITS       = 7;
  // growth of the sum over all eight bins
  localparam int unsigned SUM_GROW_BITS  = 3;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LEVEL_THRESHOLD   = 3'd0,
    CFG_TWIST_MIN         = 3'd1,
    CFG_TWIST_MAX         = 3'd2,
    CFG_OFFSET_RATIO_ROW  = 3'd3,
    CFG_OFFSET_RATIO_COL  = 3'd4,
    CFG_ENERGY_WEIGHT_ROW = 3'd5,
    CFG_ENERGY_WEIGHT_COL = 3'd6,
    CFG_ENERGY_WEIGHT_SUM = 3'd7
  } cfg_reg_e;

  // per-group test results handed from a lane to the merge stage
  typedef struct packed {
    logic [BIN_IDX_BITS-1:0] idx;
    logic                    level_ok;
    logic                    offset_ok;
    logic                    energy_ok;
    logic                    harmonic_ok;
  } lane_stat_t;

  // keypad character of a row/column pair
  function automatic logic [KEY_BITS-1:0] keypad_char(input logic [BIN_IDX_BITS-1:0] ri,
                                                      input logic [BIN_IDX_BITS-1:0] ci);
    logic [KEY_BITS-1:0] ch;
    case ({ri, ci})
      4'd0:    ch = 7'h31; // 1
      4'd1:    ch = 7'h32; // 2
      4'd2:    ch = 7'h33; // 3
      4'd3:    ch = 7'h41; // A
      4'd4:    ch = 7'h34; // 4
      4'd5:    ch = 7'h35; // 5
      4'd6:    ch = 7'h36; // 6
      4'd7:    ch = 7'h42; // B
      4'd8:    ch = 7'h37; // 7
      4'd9:    ch = 7'h38; // 8
      4'd10:   ch = 7'h39; // 9
      4'd11:   ch = 7'h43; // C
      4'd12:   ch = 7'h2A; // *
      4'd13:   ch = 7'h30; // 0
      4'd14:   ch = 7'h23; // #
      4'd15:   ch = 7'h44; // D
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

[rtl/dtv_lane.sv]
// ----------------------------------------------------------------------------
// dtv_lane: per-group tone checks
// Peak search, level, offset, weighted energy and harmonic tests for one
// group of four bins, pipelined over the stage 1 and stage 2 registers.
// ----------------------------------------------------------------------------
module dtv_lane #(
  parameter int unsigned ENERGY_BITS     = dtv_pkg::ENERGY_BITS_DEF,
  parameter int unsigned RATIO_FRAC_BITS = dtv_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       adv_i,
  input  logic [dtv_pkg::GROUP_BINS-1:0][ENERGY_BITS-1:0] energy_i,
  input  logic [ENERGY_BITS-1:0]                     harmonic_i,
  input  logic [ENERGY_BITS-1:0]                     level_threshold_i,
  input  logic [dtv_pkg::RATIO_BITS-1:0]             offset_ratio_i,
  input  logic [dtv_pkg::RATIO_BITS-1:0]             weight_i,
  input  logic [ENERGY_BITS+dtv_pkg::SUM_GROW_BITS+dtv_pkg::RATIO_BITS-1:0] wsum_i,
  output logic [ENERGY_BITS-1:0]                     peak_o,
  output dtv_pkg::lane_stat_t                        stat_o
);
  import dtv_pkg::*;

  localparam int unsigned PB = ENERGY_BITS + RATIO_BITS;
  localparam int unsigned WB = ENERGY_BITS + SUM_GROW_BITS + RATIO_BITS;

  // stage 1 registers
  logic [GROUP_BINS-1:0][ENERGY_BITS-1:0] e1_q;
  logic [ENERGY_BITS-1:0]                 h1_q;
  logic [ENERGY_BITS-1:0]                 pk1_q, pk1_d;
  logic [BIN_IDX_BITS-1:0]                idx1_q, idx1_d;

  // stage 2 registers
  logic [GROUP_BINS-1:0][ENERGY_BITS-1:0] e2_q;
  logic [BIN_IDX_BITS-1:0]                idx2_q;
  logic [PB-1:0]                          poff2_q;
  logic [GROUP_BINS-1:0][PB-1:0]          wprod2_q;
  logic                                   lvl2_q, lvl2_d;
  logic                                   harm2_q, harm2_d;

  logic offset_ok, energy_ok;

  // peak search, lowest index wins ties
  always_comb begin
    idx1_d = '0;
    pk1_d  = energy_i[0];
    for (int i = 1; i < GROUP_BINS; i++) begin
      if (energy_i[i] > pk1_d) begin
        pk1_d  = energy_i[i];
        idx1_d = BIN_IDX_BITS'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e1_q   <= energy_i;
      h1_q   <= harmonic_i;
      pk1_q  <= pk1_d;
      idx1_q <= idx1_d;
    end
  end

  // level and harmonic checks on the peak
  always_comb begin
    lvl2_d  = pk1_q > level_threshold_i;
    harm2_d = {h1_q, 1'b0} <= ({1'b0, pk1_q} + (ENERGY_BITS+1)'(1));
  end

  // scaled peak and weighted bins
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e2_q    <= e1_q;
      idx2_q  <= idx1_q;
      lvl2_q  <= lvl2_d;
      harm2_q <= harm2_d;
      poff2_q <= PB'(pk1_q) * PB'(offset_ratio_i);
      for (int i = 0; i < GROUP_BINS; i++) begin
        wprod2_q[i] <= PB'(e1_q[i]) * PB'(weight_i);
      end
    end
  end

  // offset compares over the bins other than the peak, energy compares over all bins
  always_comb begin
    offset_ok = 1'b1;
    energy_ok = 1'b1;
    for (int i = 0; i < GROUP_BINS; i++) begin
      if ((BIN_IDX_BITS'(i) != idx2_q) &&
          ((PB'(e2_q[i]) << RATIO_FRAC_BITS) > poff2_q)) begin
        offset_ok = 1'b0;
      end
      if (WB'(wprod2_q[i]) < wsum_i) begin
        energy_ok = 1'b0;
      end
    end
  end

  assign peak_o             = pk1_q;
  assign stat_o.idx         = idx2_q;
  assign stat_o.level_ok    = lvl2_q;
  assign stat_o.offset_ok   = offset_ok;
  assign stat_o.energy_ok   = energy_ok;
  assign stat_o.harmonic_ok = harm2_q;

endmodule

[rtl/dtv_merge.sv]
// ----------------------------------------------------------------------------
// dtv_merge: cross-group tests and result register
// Total energy, twist window, flag merge and keypad decode.
// ----------------------------------------------------------------------------
module dtv_merge #(
  parameter int unsigned ENERGY_BITS     = dtv_pkg::ENERGY_BITS_DEF,
  parameter int unsigned RATIO_FRAC_BITS = dtv_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       adv_i,
  input  logic [dtv_pkg::GROUP_BINS-1:0][ENERGY_BITS-1:0] row_energy_i,
  input  logic [dtv_pkg::GROUP_BINS-1:0][ENERGY_BITS-1:0] col_energy_i,
  input  logic [ENERGY_BITS-1:0]                     row_peak_i,
  input  logic [ENERGY_BITS-1:0]                     col_peak_i,
  input  logic [dtv_pkg::RATIO_BITS-1:0]             twist_min_i,
  input  logic [dtv_pkg::RATIO_BITS-1:0]             twist_max_i,
  input  logic [dtv_pkg::RATIO_BITS-1:0]             weight_sum_i,
  input  dtv_pkg::lane_stat_t                        row_stat_i,
  input  dtv_pkg::lane_stat_t                        col_stat_i,
  output logic [ENERGY_BITS+dtv_pkg::SUM_GROW_BITS+dtv_pkg::RATIO_BITS-1:0] wsum_o,
  output logic                                       detected_o,
  output logic [dtv_pkg::KEY_BITS-1:0]               key_char_o,
  output logic [dtv_pkg::BIN_IDX_BITS-1:0]           row_index_o,
  output logic [dtv_pkg::BIN_IDX_BITS-1:0]           col_index_o,
  output logic                                       level_ok_o,
  output logic                                       twist_ok_o,
  output logic                                       offset_ok_o,
  output logic                                       energy_ok_o,
  output logic                                       harmonic_ok_o
);
  import dtv_pkg::*;

  localparam int unsigned SB = ENERGY_BITS + SUM_GROW_BITS;
  localparam int unsigned PB = ENERGY_BITS + RATIO_BITS;
  localparam int unsigned WB = SB + RATIO_BITS;

  logic [SB-1:0] sum1_q, sum1_d;
  logic [WB-1:0] wsum2_q;
  logic [PB-1:0] tmin2_q, tmax2_q, csh2_q;
  logic          lv, tw, of, en, hm, det;

  // sum of all eight bins, as two group sums
  always_comb begin
    logic [SB-1:0] rsum, csum;
    rsum = '0;
    csum = '0;
    for (int i = 0; i < GROUP_BINS; i++) begin
      rsum = rsum + SB'(row_energy_i[i]);
      csum = csum + SB'(col_energy_i[i]);
    end
    sum1_d = rsum + csum;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      sum1_q <= sum1_d;
    end
  end

  // weighted total and twist bounds scaled by the row peak
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      wsum2_q <= WB'(sum1_q) * WB'(weight_sum_i);
      tmin2_q <= PB'(row_peak_i) * PB'(twist_min_i);
      tmax2_q <= PB'(row_peak_i) * PB'(twist_max_i);
      csh2_q  <= PB'(col_peak_i) << RATIO_FRAC_BITS;
    end
  end

  assign wsum_o = wsum2_q;

  // merge flags of both lanes
  always_comb begin
    lv  = row_stat_i.level_ok && col_stat_i.level_ok;
    tw  = (csh2_q > tmin2_q) && (csh2_q < tmax2_q);
    of  = row_stat_i.offset_ok && col_stat_i.offset_ok;
    en  = row_stat_i.energy_ok && col_stat_i.energy_ok;
    hm  = row_stat_i.harmonic_ok && col_stat_i.harmonic_ok;
    det = lv && tw && of && en && hm;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      detected_o    <= det;
      key_char_o    <= det ? keypad_char(row_stat_i.idx, col_stat_i.idx) : '0;
      row_index_o   <= row_stat_i.idx;
      col_index_o   <= col_stat_i.idx;
      level_ok_o    <= lv;
      twist_ok_o    <= tw;
      offset_ok_o   <= of;
      energy_ok_o   <= en;
      harmonic_ok_o <= hm;
    end
  end

endmodule

[rtl/dtmf_tone_validator_decoder.sv]
// ----------------------------------------------------------------------------
// dtmf_tone_validator_decoder: dtmf tone validation and digit decode
// Row and column lanes run the per-group tests, the merge stage applies the
// twist test, combines the flags and decodes the keypad character.
// A frame's result moves through the stage 1, stage 2 and result registers.
// Throughput: one frame per cycle; the whole pipeline holds only while a
// finished result is stalled at the output.
// Reset clears the pipeline valids and loads the configuration defaults.
// ----------------------------------------------------------------------------
module dtmf_tone_validator_decoder #(
  parameter int unsigned ENERGY_BITS     = dtv_pkg::ENERGY_BITS_DEF,
  parameter int unsigned RATIO_FRAC_BITS = dtv_pkg::RATIO_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dtv_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [dtv_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  // frame input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ENERGY_BITS-1:0]             row_energy_0_i,
  input  logic [ENERGY_BITS-1:0]             row_energy_1_i,
  input  logic [ENERGY_BITS-1:0]             row_energy_2_i,
  input  logic [ENERGY_BITS-1:0]             row_energy_3_i,
  input  logic [ENERGY_BITS-1:0]             col_energy_0_i,
  input  logic [ENERGY_BITS-1:0]             col_energy_1_i,
  input  logic [ENERGY_BITS-1:0]             col_energy_2_i,
  input  logic [ENERGY_BITS-1:0]             col_energy_3_i,
  input  logic [ENERGY_BITS-1:0]             row_harmonic_i,
  input  logic [ENERGY_BITS-1:0]             col_harmonic_i,
  // result output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               detected_o,
  output logic [dtv_pkg::KEY_BITS-1:0]       key_char_o,
  output logic [dtv_pkg::BIN_IDX_BITS-1:0]   row_index_o,
  output logic [dtv_pkg::BIN_IDX_BITS-1:0]   col_index_o,
  output logic                               level_ok_o,
  output logic                               twist_ok_o,
  output logic                               offset_ok_o,
  output logic                               energy_ok_o,
  output logic                               harmonic_ok_o
);
  import dtv_pkg::*;

  localparam int unsigned WB = ENERGY_BITS + SUM_GROW_BITS + RATIO_BITS;

  // reset values in the ratio format: 0.15, 2.5, 0.5 and 1.0
  localparam logic [RATIO_BITS-1:0] TwistMinRst = RATIO_BITS'((15 << RATIO_FRAC_BITS) / 100);
  localparam logic [RATIO_BITS-1:0] TwistMaxRst = RATIO_BITS'((5 << RATIO_FRAC_BITS) / 2);
  localparam logic [RATIO_BITS-1:0] HalfRst     = RATIO_BITS'(1 << (RATIO_FRAC_BITS - 1));
  localparam logic [RATIO_BITS-1:0] OneRst      = RATIO_BITS'(1 << RATIO_FRAC_BITS);

  // configuration registers
  logic [ENERGY_BITS-1:0] level_threshold_q;
  logic [RATIO_BITS-1:0]  twist_min_q, twist_max_q;
  logic [RATIO_BITS-1:0]  offset_ratio_row_q, offset_ratio_col_q;
  logic [RATIO_BITS-1:0]  energy_weight_row_q, energy_weight_col_q, energy_weight_sum_q;

  // pipeline control
  logic v1_q, v2_q, out_valid_q;
  logic adv;

  logic [GROUP_BINS-1:0][ENERGY_BITS-1:0] row_energy, col_energy;
  logic [ENERGY_BITS-1:0] row_peak, col_peak;
  logic [WB-1:0]          wsum;
  lane_stat_t             row_stat, col_stat;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_threshold_q   <= '0;
      twist_min_q         <= TwistMinRst;
      twist_max_q         <= TwistMaxRst;
      offset_ratio_row_q  <= HalfRst;
      offset_ratio_col_q  <= HalfRst;
      energy_weight_row_q <= OneRst;
      energy_weight_col_q <= OneRst;
      energy_weight_sum_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_LEVEL_THRESHOLD:   level_threshold_q   <= cfg_wdata_i[ENERGY_BITS-1:0];
        CFG_TWIST_MIN:         twist_min_q         <= cfg_wdata_i[RATIO_BITS-1:0];
        CFG_TWIST_MAX:         twist_max_q         <= cfg_wdata_i[RATIO_BITS-1:0];
        CFG_OFFSET_RATIO_ROW:  offset_ratio_row_q  <= cfg_wdata_i[RATIO_BITS-1:0];
        CFG_OFFSET_RATIO_COL:  offset_ratio_col_q  <= cfg_wdata_i[RATIO_BITS-1:0];
        CFG_ENERGY_WEIGHT_ROW: energy_weight_row_q <= cfg_wdata_i[RATIO_BITS-1:0];
        CFG_ENERGY_WEIGHT_COL: energy_weight_col_q <= cfg_wdata_i[RATIO_BITS-1:0];
        CFG_ENERGY_WEIGHT_SUM: energy_weight_sum_q <= cfg_wdata_i[RATIO_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless a finished result is held
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  // group the bins for the lanes
  assign row_energy = {row_energy_3_i, row_energy_2_i, row_energy_1_i, row_energy_0_i};
  assign col_energy = {col_energy_3_i, col_energy_2_i, col_energy_1_i, col_energy_0_i};

  dtv_lane #(
    .ENERGY_BITS     (ENERGY_BITS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_row_lane (
    .clk_i             (clk_i),
    .adv_i             (adv),
    .energy_i          (row_energy),
    .harmonic_i        (row_harmonic_i),
    .level_threshold_i (level_threshold_q),
    .offset_ratio_i    (offset_ratio_row_q),
    .weight_i          (energy_weight_row_q),
    .wsum_i            (wsum),
    .peak_o            (row_peak),
    .stat_o            (row_stat)
  );

  dtv_lane #(
    .ENERGY_BITS     (ENERGY_BITS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_col_lane (
    .clk_i             (clk_i),
    .adv_i             (adv),
    .energy_i          (col_energy),
    .harmonic_i        (col_harmonic_i),
    .level_threshold_i (level_threshold_q),
    .offset_ratio_i    (offset_ratio_col_q),
    .weight_i          (energy_weight_col_q),
    .wsum_i            (wsum),
    .peak_o            (col_peak),
    .stat_o            (col_stat)
  );

  dtv_merge #(
    .ENERGY_BITS     (ENERGY_BITS),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_merge (
    .clk_i         (clk_i),
    .adv_i         (adv),
    .row_energy_i  (row_energy),
    .col_energy_i  (col_energy),
    .row_peak_i    (row_peak),
    .col_peak_i    (col_peak),
    .twist_min_i   (twist_min_q),
    .twist_max_i   (twist_max_q),
    .weight_sum_i  (energy_weight_sum_q),
    .row_stat_i    (row_stat),
    .col_stat_i    (col_stat),
    .wsum_o        (wsum),
    .detected_o    (detected_o),
    .key_char_o    (key_char_o),
    .row_index_o   (row_index_o),
    .col_index_o   (col_index_o),
    .level_ok_o    (level_ok_o),
    .twist_ok_o    (twist_ok_o),
    .offset_ok_o   (offset_ok_o),
    .energy_ok_o   (energy_ok_o),
    .harmonic_ok_o (harmonic_ok_o)
  );

endmodule
